// ===== rtl/bwalu_pkg.sv =====
package bwalu_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned OpW   = 4;
  localparam int unsigned FlagW = 4;

  typedef logic [OpW-1:0]   op_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [FlagW-1:0] flags_t;

  localparam op_t OP_ADD   = 4'd0;
  localparam op_t OP_SUB   = 4'd1;
  localparam op_t OP_ADDX  = 4'd2;
  localparam op_t OP_SUBX  = 4'd3;
  localparam op_t OP_ADDS  = 4'd4;
  localparam op_t OP_SUBS  = 4'd5;
  localparam op_t OP_DADD  = 4'd6;
  localparam op_t OP_SHLL  = 4'd7;
  localparam op_t OP_SHLR  = 4'd8;
  localparam op_t OP_ROTL  = 4'd9;
  localparam op_t OP_ROTR  = 4'd10;
  localparam op_t OP_ROTXL = 4'd11;
  localparam op_t OP_ROTXR = 4'd12;
  localparam op_t OP_SHAL  = 4'd13;
  localparam op_t OP_SHAR  = 4'd14;

  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [5:0] BCD_LO_LIMIT = 6'h0a;
  localparam logic [5:0] BCD_LO_ADJ   = 6'h06;
  localparam logic [9:0] BCD_HI_LIMIT = 10'h0a0;
  localparam logic [9:0] BCD_HI_ADJ   = 10'h060;

endpackage

// ===== rtl/bwalu_if.sv =====
interface bwalu_in_if;
  import bwalu_pkg::*;

  logic   valid;
  logic   ready;
  op_t    req_type;
  logic   word_size;
  word_t  operand_a;
  word_t  operand_b;
  flags_t flags_in;

  modport source (output valid, req_type, word_size, operand_a, operand_b, flags_in,
                  input ready);
  modport sink (input valid, req_type, word_size, operand_a, operand_b, flags_in,
                output ready);
endinterface

interface bwalu_out_if;
  import bwalu_pkg::*;

  logic   valid;
  logic   ready;
  word_t  result;
  flags_t flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink (input valid, result, flags_out, output ready);
endinterface

// ===== rtl/byte_word_alu_with_flags.sv =====
// Byte and word ALU with N Z V C flags. Each request carries an operation code, a size, two
// operands and the incoming flags, and returns one result with the new flags. A request is taken
// every clock cycle when the result side keeps up; an accepted request passes through the input
// register and then the result register, with the whole operation done by the logic between them.
// Byte operations and decimal add return a result with the upper eight bits zero.
module byte_word_alu_with_flags (
  input logic         clk,
  input logic         rst_n,
  bwalu_in_if.sink    in_ch,
  bwalu_out_if.source out_ch
);
  import bwalu_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  op_t    op_r;
  logic   word_size_r;
  word_t  opa_r;
  word_t  opb_r;
  flags_t fin_r;

  logic   out_valid_r, out_valid_nxt;
  word_t  result_r, result_nxt;
  flags_t flags_r, flags_nxt;

  logic   out_free;
  logic   in_fire;

  logic        word;
  word_t       a;
  word_t       b;
  logic        cin;
  logic        cin_use;
  logic        msb_a;
  logic        msb2_a;
  logic [16:0] sum;
  logic [16:0] diff;
  logic [4:0]  dl;
  logic [5:0]  dlc;
  logic [9:0]  dh;
  logic [9:0]  dfin;
  logic        lsb_in;
  logic        msb_in;
  word_t       shl_res;
  word_t       shr_res;
  word_t       res;
  logic        res_n;
  logic        res_z;
  logic        carry;
  logic        ovf_add;
  logic        ovf_sub;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.result    = result_r;
  assign out_ch.flags_out = flags_r;

  assign s1_valid_nxt  = in_ch.ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_ch.req_type;
      word_size_r <= in_ch.word_size;
      opa_r       <= in_ch.operand_a;
      opb_r       <= in_ch.operand_b;
      fin_r       <= in_ch.flags_in;
    end
    if (out_free && s1_valid_r) begin
      result_r <= result_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_comb begin
    word    = word_size_r && (op_r != OP_DADD);
    a       = word ? opa_r : {8'h00, opa_r[7:0]};
    b       = word ? opb_r : {8'h00, opb_r[7:0]};
    cin     = fin_r[FLAG_C];
    cin_use = ((op_r == OP_ADDX) || (op_r == OP_SUBX)) ? cin : 1'b0;
    msb_a   = word ? a[15] : a[7];
    msb2_a  = word ? a[14] : a[6];

    sum  = {1'b0, a} + {1'b0, b} + {16'h0000, cin_use};
    diff = {1'b0, a} - {1'b0, b} - {16'h0000, cin_use};

    dl   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
    dlc  = ({1'b0, dl} >= BCD_LO_LIMIT) ? ({1'b0, dl} + BCD_LO_ADJ) : {1'b0, dl};
    dh   = {4'h0, dlc} + {2'b00, a[7:4], 4'h0} + {2'b00, b[7:4], 4'h0};
    dfin = (dh >= BCD_HI_LIMIT) ? (dh + BCD_HI_ADJ) : dh;

    case (op_r)
      OP_ROTL:  lsb_in = msb_a;
      OP_ROTXL: lsb_in = cin;
      default:  lsb_in = 1'b0;
    endcase
    case (op_r)
      OP_ROTR:  msb_in = a[0];
      OP_ROTXR: msb_in = cin;
      OP_SHAR:  msb_in = msb_a;
      default:  msb_in = 1'b0;
    endcase
    shl_res = word ? {a[14:0], lsb_in} : {8'h00, a[6:0], lsb_in};
    shr_res = word ? {msb_in, a[15:1]} : {8'h00, msb_in, a[7:1]};

    case (op_r) inside
      OP_ADD, OP_ADDX, OP_ADDS: res = word ? sum[15:0] : {8'h00, sum[7:0]};
      OP_SUB, OP_SUBX, OP_SUBS: res = word ? diff[15:0] : {8'h00, diff[7:0]};
      OP_DADD:                  res = {8'h00, dfin[7:0]};
      OP_SHLL, OP_SHAL, OP_ROTL, OP_ROTXL: res = shl_res;
      OP_SHLR, OP_SHAR, OP_ROTR, OP_ROTXR: res = shr_res;
      default:                  res = a;
    endcase

    res_n   = word ? res[15] : res[7];
    res_z   = (res == '0);
    ovf_add = word ? (~(a[15] ^ b[15]) & (a[15] ^ sum[15]))
                   : (~(a[7] ^ b[7]) & (a[7] ^ sum[7]));
    ovf_sub = word ? ((a[15] ^ b[15]) & (a[15] ^ diff[15]))
                   : ((a[7] ^ b[7]) & (a[7] ^ diff[7]));

    carry = 1'b0;
    flags_nxt = fin_r;
    case (op_r) inside
      OP_ADD, OP_ADDX: begin
        carry = word ? sum[16] : sum[8];
        flags_nxt[FLAG_N] = res_n;
        flags_nxt[FLAG_Z] = (op_r == OP_ADD) ? res_z : (fin_r[FLAG_Z] & res_z);
        flags_nxt[FLAG_V] = ovf_add;
        flags_nxt[FLAG_C] = carry;
      end
      OP_SUB, OP_SUBX: begin
        carry = word ? diff[16] : diff[8];
        flags_nxt[FLAG_N] = res_n;
        flags_nxt[FLAG_Z] = (op_r == OP_SUB) ? res_z : (fin_r[FLAG_Z] & res_z);
        flags_nxt[FLAG_V] = ovf_sub;
        flags_nxt[FLAG_C] = carry;
      end
      OP_DADD: begin
        carry = dfin[8];
        flags_nxt[FLAG_Z] = fin_r[FLAG_Z] & res_z;
        flags_nxt[FLAG_C] = carry;
      end
      OP_SHLL, OP_SHAL, OP_ROTL, OP_ROTXL: begin
        flags_nxt[FLAG_N] = res_n;
        flags_nxt[FLAG_Z] = res_z;
        flags_nxt[FLAG_V] = (op_r == OP_SHAL) ? (msb_a ^ msb2_a) : 1'b0;
        flags_nxt[FLAG_C] = msb_a;
      end
      OP_SHLR, OP_SHAR, OP_ROTR, OP_ROTXR: begin
        flags_nxt[FLAG_N] = res_n;
        flags_nxt[FLAG_Z] = res_z;
        flags_nxt[FLAG_V] = 1'b0;
        flags_nxt[FLAG_C] = a[0];
      end
      default: begin
        flags_nxt = fin_r;
      end
    endcase

    result_nxt = res;
  end

`ifndef SYNTHESIS
  // A request held in the input register while the result is stalled blocks new requests.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while the input register is full and stalled");

  // An accepted request always reaches the input register.
  a_in_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted request lost before the input register");

  // A request that moves on from the input register is shown as a result next cycle.
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_valid_r)
    else $error("request lost between the input and result registers");
`endif

endmodule

// ===== bench/byte_word_alu_with_flags_test.sv =====
module byte_word_alu_with_flags_test;
  import bwalu_pkg::*;

  localparam op_t OP_UNUSED = 4'd15;

  localparam flags_t F_NONE = '0;
  localparam flags_t F_N = flags_t'(1 << FLAG_N);
  localparam flags_t F_Z = flags_t'(1 << FLAG_Z);
  localparam flags_t F_V = flags_t'(1 << FLAG_V);
  localparam flags_t F_C = flags_t'(1 << FLAG_C);
  localparam flags_t F_ALL = F_N | F_Z | F_V | F_C;

  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_REQUESTS = 1125;
  localparam int LONG_HOLD = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    op_t    op;
    logic   word;
    word_t  a;
    word_t  b;
    flags_t fin;
    logic   known;
    word_t  result;
    flags_t flags;
  } alu_request_t;

  logic clk;
  logic rst_n;

  bwalu_in_if  in_ch ();
  bwalu_out_if out_ch ();

  byte_word_alu_with_flags u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  alu_request_t pending_results[$];
  int           mismatch_count;
  int           received_count;
  int           cycle_count;

  // The result is typed in only where it is plain to see; other rows use alu_compute.
  alu_request_t directed_rows [DIRECTED_COUNT] = '{
    '{OP_ADD,    1'b0, 16'h00FF, 16'h0001, F_NONE,    1'b1, 16'h0000, F_Z | F_C},
    '{OP_ADD,    1'b1, 16'hFFFF, 16'h0001, F_NONE,    1'b1, 16'h0000, F_Z | F_C},
    '{OP_ADD,    1'b1, 16'h7FFF, 16'h0001, F_NONE,    1'b1, 16'h8000, F_N | F_V},
    '{OP_ADD,    1'b0, 16'hFF7F, 16'hFF01, F_NONE,    1'b0, 16'h0000, F_NONE},
    '{OP_SUB,    1'b0, 16'h0000, 16'h0001, F_NONE,    1'b1, 16'h00FF, F_N | F_C},
    '{OP_SUB,    1'b1, 16'h8000, 16'h0001, F_NONE,    1'b1, 16'h7FFF, F_V},
    '{OP_ADDX,   1'b0, 16'h00FF, 16'h0000, F_Z | F_C, 1'b1, 16'h0000, F_Z | F_C},
    '{OP_ADDX,   1'b1, 16'h0000, 16'h0000, F_C,       1'b0, 16'h0000, F_NONE},
    '{OP_SUBX,   1'b0, 16'h0000, 16'h0000, F_Z | F_C, 1'b1, 16'h00FF, F_N | F_C},
    '{OP_SUBX,   1'b1, 16'h1234, 16'h1234, F_Z,       1'b1, 16'h0000, F_Z},
    '{OP_SUBX,   1'b1, 16'h8000, 16'h7FFF, F_C,       1'b0, 16'h0000, F_NONE},
    '{OP_ADDS,   1'b1, 16'hFFFF, 16'h0001, F_ALL,     1'b1, 16'h0000, F_ALL},
    '{OP_SUBS,   1'b0, 16'h0000, 16'h0001, F_NONE,    1'b1, 16'h00FF, F_NONE},
    '{OP_DADD,   1'b0, 16'h0099, 16'h0001, F_Z,       1'b1, 16'h0000, F_Z | F_C},
    '{OP_DADD,   1'b1, 16'h1245, 16'h3458, F_C,       1'b0, 16'h0000, F_NONE},
    '{OP_SHLL,   1'b0, 16'h0080, 16'h0000, F_NONE,    1'b1, 16'h0000, F_Z | F_C},
    '{OP_SHLR,   1'b1, 16'h0001, 16'h0000, F_ALL,     1'b1, 16'h0000, F_Z | F_C},
    '{OP_ROTL,   1'b1, 16'h8000, 16'h0000, F_NONE,    1'b1, 16'h0001, F_C},
    '{OP_ROTR,   1'b0, 16'h0001, 16'h0000, F_NONE,    1'b1, 16'h0080, F_N | F_C},
    '{OP_ROTXL,  1'b0, 16'h0000, 16'h0000, F_C,       1'b0, 16'h0000, F_NONE},
    '{OP_ROTXR,  1'b1, 16'h0001, 16'h0000, F_C,       1'b0, 16'h0000, F_NONE},
    '{OP_SHAL,   1'b0, 16'h0040, 16'h0000, F_NONE,    1'b1, 16'h0080, F_N | F_V},
    '{OP_SHAL,   1'b1, 16'hC000, 16'h0000, F_NONE,    1'b0, 16'h0000, F_NONE},
    '{OP_SHAR,   1'b1, 16'h8001, 16'h0000, F_NONE,    1'b1, 16'hC000, F_N | F_C},
    '{OP_UNUSED, 1'b0, 16'hABCD, 16'h1234, F_N | F_V, 1'b1, 16'h00CD, F_N | F_V}
  };

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = OP_ADD;
    in_ch.word_size = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.flags_in = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    received_count = 0;
    cycle_count = 0;
  end

  always #6 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic flags_t nz_of_size(logic [31:0] v, logic [31:0] msb, logic [31:0] mask);
    flags_t f;
    f = F_NONE;
    if ((v & mask) == 0) f[FLAG_Z] = 1'b1;
    if ((v & msb) != 0) f[FLAG_N] = 1'b1;
    return f;
  endfunction

  function automatic alu_request_t alu_compute(alu_request_t r);
    logic [31:0] mask;
    logic [31:0] msb;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic [31:0] cin;
    int unsigned top;
    logic        is_word;
    flags_t      f;
    // Decimal add always works on the low byte.
    is_word = r.word && (r.op != OP_DADD);
    mask = is_word ? 32'hFFFF : 32'hFF;
    msb = is_word ? 32'h8000 : 32'h80;
    top = is_word ? 15 : 7;
    cin = {31'd0, r.fin[FLAG_C]};
    a = {16'd0, r.a} & mask;
    b = {16'd0, r.b} & mask;
    res = a;
    f = r.fin;
    case (r.op)
      OP_ADD, OP_ADDX: begin
        res = a + b + ((r.op == OP_ADDX) ? cin : 32'd0);
        if (r.op == OP_ADD) begin
          f = nz_of_size(res, msb, mask);
        end else begin
          f = F_NONE;
          f[FLAG_Z] = r.fin[FLAG_Z] && ((res & mask) == 0);
        end
        if ((res & msb) != 0) f[FLAG_N] = 1'b1;
        if ((~(a ^ b) & (a ^ res) & msb) != 0) f[FLAG_V] = 1'b1;
        if ((res & (mask + 1)) != 0) f[FLAG_C] = 1'b1;
      end
      OP_SUB, OP_SUBX: begin
        res = a - b - ((r.op == OP_SUBX) ? cin : 32'd0);
        if (r.op == OP_SUB) begin
          f = nz_of_size(res, msb, mask);
        end else begin
          f = F_NONE;
          f[FLAG_Z] = r.fin[FLAG_Z] && ((res & mask) == 0);
        end
        if ((res & msb) != 0) f[FLAG_N] = 1'b1;
        if (((a ^ b) & (a ^ res) & msb) != 0) f[FLAG_V] = 1'b1;
        if ((res & (mask + 1)) != 0) f[FLAG_C] = 1'b1;
      end
      OP_ADDS: res = a + b;
      OP_SUBS: res = a - b;
      OP_DADD: begin
        res = (a & 32'h0F) + (b & 32'h0F) + cin;
        if (res >= BCD_LO_LIMIT) res = res + BCD_LO_ADJ;
        res = res + (a & 32'hF0) + (b & 32'hF0);
        if (res >= BCD_HI_LIMIT) res = res + BCD_HI_ADJ;
        f[FLAG_C] = ((res & 32'h100) != 0);
        if ((res & 32'hFF) != 0) f[FLAG_Z] = 1'b0;
      end
      OP_SHLL, OP_SHAL: begin
        res = (a << 1) & mask;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = ((a & msb) != 0);
        if (r.op == OP_SHAL && (a[top] ^ a[top-1])) f[FLAG_V] = 1'b1;
      end
      OP_SHLR: begin
        res = a >> 1;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = a[0];
      end
      OP_ROTL: begin
        res = ((a << 1) | (a >> top)) & mask;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = ((a & msb) != 0);
      end
      OP_ROTR: begin
        res = ((a >> 1) | ({31'd0, a[0]} << top)) & mask;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = a[0];
      end
      OP_ROTXL: begin
        res = ((a << 1) | cin) & mask;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = ((a & msb) != 0);
      end
      OP_ROTXR: begin
        res = ((a >> 1) | (cin << top)) & mask;
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = a[0];
      end
      OP_SHAR: begin
        res = (a >> 1) | (a & msb);
        f = nz_of_size(res, msb, mask);
        f[FLAG_C] = a[0];
      end
      default: ;
    endcase
    r.result = word_t'(res & mask);
    r.flags = f;
    r.known = 1'b1;
    return r;
  endfunction

  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return {8'($urandom), 8'h80};
      5: return {8'($urandom), 8'h7F};
      6: return {8'($urandom), 8'hFF};
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_bcd();
    return {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  function automatic alu_request_t random_request();
    alu_request_t r;
    r = '0;
    if ($urandom_range(0, 39) == 0) r.op = OP_UNUSED;
    else r.op = op_t'($urandom_range(OP_ADD, OP_SHAR));
    r.word = 1'($urandom);
    r.fin = flags_t'($urandom_range(0, 15));
    if (r.op == OP_DADD && $urandom_range(0, 3) != 0) begin
      r.a = pick_bcd();
      r.b = pick_bcd();
    end else begin
      r.a = pick_operand();
      // Operand pairs that cancel reach the zero and sticky-Z paths.
      case ($urandom_range(0, 5))
        0: r.b = r.a;
        1: r.b = -r.a;
        default: r.b = pick_operand();
      endcase
    end
    return alu_compute(r);
  endfunction

  task automatic report_mismatch(input string what, input alu_request_t r, input int got);
    $display("mismatch %s: op %0d word %0b a %h b %h flags %h got %h expected %h",
             what, r.op, r.word, r.a, r.b, r.fin, got,
             (what == "result") ? int'(r.result) : int'(r.flags));
    mismatch_count++;
  endtask

  task automatic issue_request(input alu_request_t r, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.op;
    in_ch.word_size <= r.word;
    in_ch.operand_a <= r.a;
    in_ch.operand_b <= r.b;
    in_ch.flags_in <= r.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  initial begin : request_driver
    alu_request_t r;
    int gap;
    wait (rst_n);
    @(posedge clk);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      r = directed_rows[i];
      if (!r.known) r = alu_compute(r);
      issue_request(r, $urandom_range(0, 7));
    end
    drain_results();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain_results();
      // Back-to-back stretches; the first one overlaps the long result hold-off.
      if ((i >= 280 && i < 420) || (i >= 900 && i < 960)) gap = 0;
      else gap = $urandom_range(0, 7);
      issue_request(random_request(), gap);
    end
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_checker
    alu_request_t r;
    int stall;
    wait (rst_n);
    forever begin
      if (received_count == 330) stall = LONG_HOLD;
      else if (received_count >= 600 && received_count < 700) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      received_count++;
      if (pending_results.size() == 0) begin
        r = '0;
        report_mismatch("unexpected", r, int'(out_ch.result));
      end else begin
        r = pending_results.pop_front();
        if (out_ch.result !== r.result) report_mismatch("result", r, int'(out_ch.result));
        if (out_ch.flags_out !== r.flags) report_mismatch("flags", r, int'(out_ch.flags_out));
      end
    end
  end

endmodule

// ===== files.f =====
rtl/bwalu_pkg.sv
rtl/bwalu_if.sv
rtl/byte_word_alu_with_flags.sv
bench/byte_word_alu_with_flags_test.sv
